### src/ttoe_pkg.sv
// ttoe_pkg: shared types, constants and the pair code table for the
// ternary-to-octet encoder. No dependencies.
package ttoe_pkg;

   localparam int POLY_LEN_W         = 11;
   localparam int COEFF_W            = 2;
   localparam int BYTE_W             = 8;
   localparam int BYTES_SENT_W       = 10;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = POLY_LEN_W;
   localparam int DEFAULT_MAX_COEFFS = 2048;
   localparam int MAX_COEFFS_W       = 13;   // holds the largest allowed MAX_COEFFS
   localparam int FIFO_DEPTH         = 4;
   localparam int FIFO_PTR_W         = 2;
   localparam int FIFO_CNT_W         = 3;

   localparam logic [POLY_LEN_W-1:0] POLY_LEN_RESET = 11'd743;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLY_LEN      = 1'b0,
      CSR_SKIP_CONSTANT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              invalid_pair;
      logic              last_byte;
   } result_type;

   // results produced by one coefficient, in order; count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   // 3 bits for pair index 3*(a+1)+(b+1), bit 0 goes out first
   function automatic logic [2:0] pair_bits(input logic [3:0] idx);
      logic [2:0] bits;
      case (idx)
         4'd0:    bits = 3'd7;
         4'd1:    bits = 3'd3;
         4'd2:    bits = 3'd7;
         4'd3:    bits = 3'd2;
         4'd4:    bits = 3'd0;
         4'd5:    bits = 3'd4;
         4'd6:    bits = 3'd5;
         4'd7:    bits = 3'd6;
         default: bits = 3'd1;
      endcase
      return bits;
   endfunction

endpackage

### src/ttoe_core.sv
// ttoe_core: per-polynomial stream state, pair coding, bit packing and
// end-of-polynomial flush. Depends on ttoe_pkg.
module ttoe_core #(
   parameter int MAX_COEFFS = ttoe_pkg::DEFAULT_MAX_COEFFS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic signed [ttoe_pkg::COEFF_W-1:0] coefficient,
   input  logic [ttoe_pkg::POLY_LEN_W-1:0]     poly_len,
   input  logic                                skip_constant,
   output ttoe_pkg::push_type                  push
);

   localparam int LW = ttoe_pkg::POLY_LEN_W;
   localparam int SW = ttoe_pkg::BYTES_SENT_W;
   localparam int CW = ttoe_pkg::MAX_COEFFS_W;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_COEFFS);

   logic [LW-1:0]     coeff_index_ff, coeff_index_in;
   logic [1:0]        held_first_ff, held_first_in;
   logic              have_first_ff, have_first_in;
   logic [7:0]        byte_accum_ff, byte_accum_in;
   logic [2:0]        bit_position_ff, bit_position_in;
   logic [SW-1:0]     bytes_sent_ff, bytes_sent_in;
   logic              dropping_ff, dropping_in;

   logic [1:0]        trit;
   logic [CW-1:0]     len_ext;
   logic [LW-1:0]     nn;
   logic              last;
   logic [12:0]       triple;
   logic [12:0]       total_sum;
   logic [SW-1:0]     total;
   logic [3:0]        pair_idx;
   logic [10:0]       merged;
   logic              byte_full;
   logic              pair_emit;
   ttoe_pkg::result_type pair_res;
   logic              drop_new;
   logic [7:0]        acc1;
   logic [2:0]        pos1;
   logic [SW-1:0]     sent1, sent2;
   logic              fl_a, fl_b;
   logic              mark_last;

   function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] v, input logic en);
      logic [SW-1:0] r;
      r = v;
      if (en && (v != {SW{1'b1}})) r = v + SW'(1);
      return r;
   endfunction

   // code 10 counts as minus one; stored as coefficient+1
   assign trit = coefficient[1] ? 2'd0 : ((coefficient == 2'sd1) ? 2'd2 : 2'd1);

   always_comb begin
      len_ext = {{(CW-LW){1'b0}}, poly_len};
      if (len_ext > MAX_LEN) len_ext = MAX_LEN;
      if (len_ext < CW'(2))  len_ext = CW'(2);
      nn = len_ext[LW-1:0];
   end

   assign last      = coeff_index_ff >= (nn - LW'(1));
   assign triple    = {2'b00, nn} + {1'b0, nn, 1'b0} + 13'd1;
   assign total_sum = {1'b0, triple[12:1]} + 13'd7;
   assign total     = total_sum[12:3];

   assign pair_idx  = {1'b0, held_first_ff, 1'b0} + {2'b00, held_first_ff} + {2'b00, trit};
   assign merged    = {3'b000, byte_accum_ff}
                    | (11'(ttoe_pkg::pair_bits(pair_idx)) << bit_position_ff);
   assign byte_full = bit_position_ff >= 3'd5;

   always_comb begin
      held_first_in = held_first_ff;
      have_first_in = have_first_ff;
      pair_emit     = 1'b0;
      pair_res      = '0;
      drop_new      = dropping_ff;
      acc1          = byte_accum_ff;
      pos1          = bit_position_ff;
      sent1         = bytes_sent_ff;

      if (!dropping_ff && !(skip_constant && (coeff_index_ff == '0))) begin
         if (!have_first_ff) begin
            if (!last) begin
               held_first_in = trit;
               have_first_in = 1'b1;
            end
         end else begin
            have_first_in = 1'b0;
            if ((held_first_ff == 2'd0) && (trit == 2'd0)) begin
               pair_emit             = 1'b1;
               pair_res.invalid_pair = 1'b1;
               pair_res.last_byte    = 1'b1;
               drop_new              = 1'b1;
            end else begin
               pos1 = bit_position_ff + 3'd3;
               if (byte_full) begin
                  pair_emit         = 1'b1;
                  pair_res.out_byte = merged[7:0];
                  acc1              = {5'b00000, merged[10:8]};
                  sent1             = sat_inc(bytes_sent_ff, 1'b1);
               end else begin
                  acc1 = merged[7:0];
               end
            end
         end
      end

      // flush: partial byte first, then zero padding, two results at most
      fl_a      = last && !drop_new && (sent1 < total);
      sent2     = sat_inc(sent1, fl_a);
      fl_b      = fl_a && !pair_emit && (sent2 < total);
      mark_last = last && !drop_new;

      push = '0;
      if (pair_emit) begin
         push.res0           = pair_res;
         push.res1.out_byte  = acc1;
         push.count          = fl_a ? 2'd2 : 2'd1;
      end else if (fl_a) begin
         push.res0.out_byte  = acc1;
         push.count          = fl_b ? 2'd2 : 2'd1;
      end else begin
         push.count          = mark_last ? 2'd1 : 2'd0;
      end
      if (mark_last) begin
         if (push.count == 2'd2) push.res1.last_byte = 1'b1;
         else                    push.res0.last_byte = 1'b1;
      end

      if (last) begin
         coeff_index_in  = '0;
         held_first_in   = '0;
         have_first_in   = 1'b0;
         byte_accum_in   = '0;
         bit_position_in = '0;
         bytes_sent_in   = '0;
         dropping_in     = 1'b0;
      end else begin
         coeff_index_in  = coeff_index_ff + LW'(1);
         byte_accum_in   = acc1;
         bit_position_in = pos1;
         bytes_sent_in   = sent1;
         dropping_in     = drop_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_index_ff  <= '0;
         held_first_ff   <= '0;
         have_first_ff   <= 1'b0;
         byte_accum_ff   <= '0;
         bit_position_ff <= '0;
         bytes_sent_ff   <= '0;
         dropping_ff     <= 1'b0;
      end else if (step) begin
         coeff_index_ff  <= coeff_index_in;
         held_first_ff   <= held_first_in;
         have_first_ff   <= have_first_in;
         byte_accum_ff   <= byte_accum_in;
         bit_position_ff <= bit_position_in;
         bytes_sent_ff   <= bytes_sent_in;
         dropping_ff     <= dropping_in;
      end
   end

endmodule

### src/ternary_to_octets_encoder.sv
// Ternary-to-octet encoder. An accepted coefficient is taken into the input register, then coded into
// the output queue once that queue has room for two results, and its results show on rsp_valid from
// there. Throughput: one coefficient per cycle; up to two results per coefficient are queued in a
// 4-entry result queue, and input stalls only while that queue holds 3 or more. Reset (synchronous,
// active high) empties the pipeline and queue, clears the stream state and sets poly_len to 743 and
// skip_constant to 0.
module ternary_to_octets_encoder #(
   parameter int MAX_COEFFS = ttoe_pkg::DEFAULT_MAX_COEFFS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ttoe_pkg::COEFF_W-1:0]   req_coefficient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ttoe_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                  rsp_invalid_pair,
   output logic                                  rsp_last_byte,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ttoe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ttoe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int PW = ttoe_pkg::FIFO_PTR_W;
   localparam int NW = ttoe_pkg::FIFO_CNT_W;

   logic [ttoe_pkg::POLY_LEN_W-1:0] poly_len_ff;
   logic                            skip_constant_ff;

   logic                                in_valid_ff, in_valid_in;
   logic signed [ttoe_pkg::COEFF_W-1:0] in_coeff_ff;

   ttoe_pkg::result_type queue_ff [ttoe_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff, count_in;

   ttoe_pkg::push_type push;
   logic               advance;
   logic               pop;
   logic [1:0]         push_count;
   ttoe_pkg::result_type head;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_len_ff      <= ttoe_pkg::POLY_LEN_RESET;
         skip_constant_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (ttoe_pkg::csr_index_type'(csr_index))
            ttoe_pkg::CSR_POLY_LEN:      poly_len_ff      <= csr_wdata;
            ttoe_pkg::CSR_SKIP_CONSTANT: skip_constant_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register; processed once the queue has room for two results
   assign advance   = in_valid_ff && (count_ff <= NW'(ttoe_pkg::FIFO_DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) in_valid_in = 1'b1;
      else if (advance)            in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_coeff_ff <= req_coefficient;
   end

   ttoe_core #(
      .MAX_COEFFS (MAX_COEFFS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .coefficient   (in_coeff_ff),
      .poly_len      (poly_len_ff),
      .skip_constant (skip_constant_ff),
      .push          (push)
   );

   // result queue
   assign push_count = advance ? push.count : 2'd0;
   assign pop        = rsp_valid && !rsp_stall;
   assign count_in   = count_ff + NW'(push_count) - NW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(push_count);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) queue_ff[wr_ptr_ff] <= push.res0;
      if (push_count == 2'd2) queue_ff[wr_ptr_ff + PW'(1)] <= push.res1;
   end

   assign head             = queue_ff[rd_ptr_ff];
   assign rsp_valid        = count_ff != '0;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_invalid_pair = head.invalid_pair;
   assign rsp_last_byte    = head.last_byte;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(ttoe_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (advance && push.count == 2'd2) |-> !push.res0.invalid_pair && !push.res1.invalid_pair)
      else $error("error result shares a transfer group");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (advance && push.count == 2'd2) |-> !push.res0.last_byte)
      else $error("last marker not on final result");

   a_stall_occupied: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && count_ff > NW'(ttoe_pkg::FIFO_DEPTH - 2))
      else $error("input stalled with room available");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && push_count == 2'd0) |=> count_ff == $past(count_ff) - NW'(1))
      else $error("queue count lost track of a transfer");

endmodule
